[rtl/core/jtl_pkg.sv]
`default_nettype none

package jtl_pkg;

    localparam int LEN_W = 16;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    // result queue depth: one result waiting plus two from the newest request
    localparam int QUEUE_DEPTH = 3;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        KIND_LBRACK  = 4'd0,
        KIND_RBRACK  = 4'd1,
        KIND_LBRACE  = 4'd2,
        KIND_RBRACE  = 4'd3,
        KIND_COLON   = 4'd4,
        KIND_COMMA   = 4'd5,
        KIND_BOOL    = 4'd6,
        KIND_NULL    = 4'd7,
        KIND_NUMBER  = 4'd8,
        KIND_STRING  = 4'd9,
        KIND_SPACE   = 4'd10,
        KIND_COMMENT = 4'd11,
        KIND_UNKNOWN = 4'd12
    } t_kind;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_LIT,
        MODE_MINUS,
        MODE_ZERO,
        MODE_INT,
        MODE_DOT,
        MODE_FRAC,
        MODE_EXP,
        MODE_EXPSIGN,
        MODE_EXPDIG,
        MODE_STR,
        MODE_WS,
        MODE_SLASH,
        MODE_COMMENT
    } t_mode;

    typedef enum logic [1:0] {
        LIT_TRUE  = 2'd0,
        LIT_FALSE = 2'd1,
        LIT_NULL  = 2'd2
    } t_lit;

    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_E  = 8'h65;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] char_in;
        logic       end_of_text;
    } t_in;

    typedef struct packed {
        t_kind            token_type;
        logic             matched;
        logic [LEN_W-1:0] token_length;
        logic             last_of_run;
    } t_out;

    typedef struct packed {
        t_mode            mode;
        logic [LEN_W-1:0] len;
        t_lit             lit_sel;
        logic [2:0]       lit_pos;
        logic             esc;
        logic             star;
    } t_lex_state;

    typedef struct packed {
        logic             valid;
        t_kind            kind;
        logic             ok;
        logic [LEN_W-1:0] len;
    } t_emit;

    localparam t_lex_state IDLE_STATE = '{
        mode: MODE_IDLE, len: '0, lit_sel: LIT_TRUE, lit_pos: 3'd0, esc: 1'b0, star: 1'b0
    };

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_ws(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic is_exp(logic [7:0] c);
        return (c == CH_LOW_E) || (c == CH_UP_E);
    endfunction

    function automatic logic [2:0] lit_len(t_lit sel);
        return (sel == LIT_FALSE) ? 3'd5 : 3'd4;
    endfunction

    function automatic t_kind lit_kind(t_lit sel);
        return (sel == LIT_TRUE || sel == LIT_FALSE) ? KIND_BOOL : KIND_NULL;
    endfunction

    // expected literal byte at a position; code 3 spells null as well
    function automatic logic [7:0] lit_char(t_lit sel, logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        unique case (sel)
            LIT_TRUE: begin
                unique case (pos)
                    3'd0:    c = "t";
                    3'd1:    c = "r";
                    3'd2:    c = "u";
                    3'd3:    c = "e";
                    default: c = 8'h00;
                endcase
            end
            LIT_FALSE: begin
                unique case (pos)
                    3'd0:    c = "f";
                    3'd1:    c = "a";
                    3'd2:    c = "l";
                    3'd3:    c = "s";
                    3'd4:    c = "e";
                    default: c = 8'h00;
                endcase
            end
            default: begin
                unique case (pos)
                    3'd0:    c = "n";
                    3'd1:    c = "u";
                    3'd2:    c = "l";
                    3'd3:    c = "l";
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic logic [LEN_W-1:0] grow(logic [LEN_W-1:0] len, logic [1:0] by);
        logic [LEN_W:0] sum;
        sum = {1'b0, len} + {{(LEN_W-1){1'b0}}, by};
        return sum[LEN_W] ? LEN_MAX : sum[LEN_W-1:0];
    endfunction

    function automatic t_emit mk_emit(t_kind k, logic ok, logic [LEN_W-1:0] n);
        t_emit e;
        e.valid = 1'b1;
        e.kind  = k;
        e.ok    = ok;
        e.len   = n;
        return e;
    endfunction

endpackage

`default_nettype wire

[rtl/core/json_token_lexer.sv]
`default_nettype none

// JSON token lexer: at most one byte per request on the input channel, tokens out.
// Input channel  (i_in_valid / o_in_ready / i_in): has_byte, char_in and
//   end_of_text. A request with end_of_text set flushes the open token.
// Output channel (o_out_valid / i_out_ready / o_out): token_type, matched,
//   token_length (saturating) and last_of_run, set on the final token that
//   a request raised. A request raises zero, one or two tokens.
// Path: a request lands in the input register; once the result queue has
//   room the lexer logic runs on it and pushes its tokens into the queue,
//   whose head entry is registered and drives o_out.
// Throughput: one request per cycle while each raises at most one token and
//   the receiver is ready. A request raising two tokens holds the input until
//   the queue has room again, since the output drains one token per cycle.
// Stall: the result queue holds three tokens; a new request is taken into
//   the lexer only while the queue has room for two, so a stalled receiver
//   stops the lexer; the input register then fills and o_in_ready drops.
// Reset (i_rst_n low, synchronous): lexer idle, no token in progress,
//   queue and input register empty.
module json_token_lexer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  jtl_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output jtl_pkg::t_out o_out
);
    import jtl_pkg::*;

    // input register
    logic       r_in_valid;
    t_in        r_in;
    logic       n_in_valid;

    // lexer state
    t_lex_state r_state;
    t_lex_state step_state;
    logic [1:0] step_n;
    t_out       step_res0;
    t_out       step_res1;

    logic       q_room;
    logic       adv;
    logic       in_acc;

    // the registered request moves into the lexer when the queue can take its tokens
    assign adv        = r_in_valid && q_room;
    assign o_in_ready = !r_in_valid || adv;
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_acc) begin
            n_in_valid = 1'b1;
        end else if (adv) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= IDLE_STATE;
        end else begin
            r_in_valid <= n_in_valid;
            if (adv) begin
                r_state <= step_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in;
        end
    end

    jtl_step u_step (
        .i_state (r_state),
        .i_item  (r_in),
        .o_state (step_state),
        .o_count (step_n),
        .o_res0  (step_res0),
        .o_res1  (step_res1)
    );

    jtl_res_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (adv ? step_n : 2'd0),
        .i_res0   (step_res0),
        .i_res1   (step_res1),
        .o_room   (q_room),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_res    (o_out)
    );

    // a held request must not change while the queue lacks room for two tokens
    a_hold_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_in))
        else $error("held request changed");

    // no request raises more than two tokens
    a_two_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |-> step_n != 2'd3)
        else $error("request raised too many tokens");

    // end of text always leaves the lexer idle
    a_flush_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in.end_of_text |=> r_state.mode == MODE_IDLE)
        else $error("lexer not idle after end of text");

    // tokens pushed show up on the output next cycle
    a_push_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && step_n != 2'd0 |=> o_out_valid)
        else $error("pushed token not visible");

endmodule

`default_nettype wire

[rtl/core/jtl_step.sv]
`default_nettype none

// One byte through the lexer: feed, restart, end-of-text flush.
module jtl_step (
    input  jtl_pkg::t_lex_state i_state,
    input  jtl_pkg::t_in        i_item,
    output jtl_pkg::t_lex_state o_state,
    output logic [1:0]          o_count,
    output jtl_pkg::t_out       o_res0,
    output jtl_pkg::t_out       o_res1
);
    import jtl_pkg::*;

    t_lex_state s;
    t_emit      ev [4];
    logic       taken;
    logic [7:0] c;
    logic [1:0] n;
    t_out       r0;
    t_out       r1;

    assign c = i_item.char_in;

    always_comb begin
        s     = i_state;
        taken = 1'b0;
        for (int j = 0; j < 4; j++) begin
            ev[j] = '0;
        end

        // feed the byte to the token in progress
        if (i_item.has_byte && i_state.mode != MODE_IDLE) begin
            unique case (s.mode)
                MODE_LIT: begin
                    if (s.lit_pos < lit_len(s.lit_sel) && c == lit_char(s.lit_sel, s.lit_pos)) begin
                        taken     = 1'b1;
                        s.len     = grow(s.len, 2'd1);
                        s.lit_pos = s.lit_pos + 3'd1;
                        if (s.lit_pos >= lit_len(s.lit_sel)) begin
                            ev[0] = mk_emit(lit_kind(s.lit_sel), 1'b1, s.len);
                            s     = IDLE_STATE;
                        end
                    end else begin
                        ev[0] = mk_emit(lit_kind(s.lit_sel), 1'b0, s.len);
                        s     = IDLE_STATE;
                    end
                end
                MODE_MINUS: begin
                    if (is_digit(c)) begin
                        taken  = 1'b1;
                        s.len  = grow(s.len, 2'd1);
                        s.mode = (c == CH_ZERO) ? MODE_ZERO : MODE_INT;
                    end else begin
                        ev[0] = mk_emit(KIND_NUMBER, 1'b0, s.len);
                        s     = IDLE_STATE;
                    end
                end
                MODE_ZERO, MODE_INT: begin
                    if (is_digit(c) || c == CH_DOT || is_exp(c)) begin
                        taken  = 1'b1;
                        s.len  = grow(s.len, 2'd1);
                        s.mode = is_digit(c) ? MODE_INT : (c == CH_DOT) ? MODE_DOT : MODE_EXP;
                    end else begin
                        ev[0] = mk_emit(KIND_NUMBER, 1'b1, s.len);
                        s     = IDLE_STATE;
                    end
                end
                MODE_DOT: begin
                    if (is_digit(c)) begin
                        taken  = 1'b1;
                        s.len  = grow(s.len, 2'd1);
                        s.mode = MODE_FRAC;
                    end else begin
                        ev[0] = mk_emit(KIND_NUMBER, 1'b0, s.len);
                        s     = IDLE_STATE;
                    end
                end
                MODE_FRAC: begin
                    if (is_digit(c) || is_exp(c)) begin
                        taken  = 1'b1;
                        s.len  = grow(s.len, 2'd1);
                        s.mode = is_digit(c) ? MODE_FRAC : MODE_EXP;
                    end else begin
                        ev[0] = mk_emit(KIND_NUMBER, 1'b1, s.len);
                        s     = IDLE_STATE;
                    end
                end
                MODE_EXP: begin
                    if (is_digit(c) || c == CH_PLUS || c == CH_MINUS) begin
                        taken  = 1'b1;
                        s.len  = grow(s.len, 2'd1);
                        s.mode = is_digit(c) ? MODE_EXPDIG : MODE_EXPSIGN;
                    end else begin
                        ev[0] = mk_emit(KIND_NUMBER, 1'b0, s.len);
                        s     = IDLE_STATE;
                    end
                end
                MODE_EXPSIGN: begin
                    if (is_digit(c)) begin
                        taken  = 1'b1;
                        s.len  = grow(s.len, 2'd1);
                        s.mode = MODE_EXPDIG;
                    end else begin
                        ev[0] = mk_emit(KIND_NUMBER, 1'b0, s.len);
                        s     = IDLE_STATE;
                    end
                end
                MODE_EXPDIG: begin
                    if (is_digit(c)) begin
                        taken = 1'b1;
                        s.len = grow(s.len, 2'd1);
                    end else begin
                        ev[0] = mk_emit(KIND_NUMBER, 1'b1, s.len);
                        s     = IDLE_STATE;
                    end
                end
                MODE_STR: begin
                    taken = 1'b1;
                    priority if (s.esc) begin
                        // backslash and escaped byte counted together
                        s.esc = 1'b0;
                        s.len = grow(s.len, 2'd2);
                    end else if (c == CH_QUOTE) begin
                        ev[0] = mk_emit(KIND_STRING, 1'b1, grow(s.len, 2'd1));
                        s     = IDLE_STATE;
                    end else if (c == CH_BSLASH) begin
                        s.esc = 1'b1;
                    end else begin
                        s.len = grow(s.len, 2'd1);
                    end
                end
                MODE_WS: begin
                    if (is_ws(c)) begin
                        taken = 1'b1;
                        s.len = grow(s.len, 2'd1);
                    end else begin
                        ev[0] = mk_emit(KIND_SPACE, 1'b1, s.len);
                        s     = IDLE_STATE;
                    end
                end
                MODE_SLASH: begin
                    if (c == CH_STAR) begin
                        taken  = 1'b1;
                        s.len  = grow(s.len, 2'd1);
                        s.mode = MODE_COMMENT;
                        s.star = 1'b0;
                    end else begin
                        ev[0] = mk_emit(KIND_COMMENT, 1'b0, s.len);
                        s     = IDLE_STATE;
                    end
                end
                MODE_COMMENT: begin
                    taken = 1'b1;
                    s.len = grow(s.len, 2'd1);
                    priority if (c == CH_STAR) begin
                        s.star = 1'b1;
                    end else if (s.star && c == CH_SLASH) begin
                        ev[0] = mk_emit(KIND_COMMENT, 1'b1, s.len);
                        s     = IDLE_STATE;
                    end else begin
                        s.star = 1'b0;
                    end
                end
                default: begin
                    s = IDLE_STATE;
                end
            endcase
        end

        // byte not taken (or nothing in progress): it opens a new token
        if (i_item.has_byte && !taken) begin
            s     = IDLE_STATE;
            s.len = {{(LEN_W-1){1'b0}}, 1'b1};
            unique case (c)
                CH_LBRACK: begin ev[1] = mk_emit(KIND_LBRACK, 1'b1, s.len); s = IDLE_STATE; end
                CH_RBRACK: begin ev[1] = mk_emit(KIND_RBRACK, 1'b1, s.len); s = IDLE_STATE; end
                CH_LBRACE: begin ev[1] = mk_emit(KIND_LBRACE, 1'b1, s.len); s = IDLE_STATE; end
                CH_RBRACE: begin ev[1] = mk_emit(KIND_RBRACE, 1'b1, s.len); s = IDLE_STATE; end
                CH_COLON:  begin ev[1] = mk_emit(KIND_COLON, 1'b1, s.len);  s = IDLE_STATE; end
                CH_COMMA:  begin ev[1] = mk_emit(KIND_COMMA, 1'b1, s.len);  s = IDLE_STATE; end
                CH_LOW_T: begin
                    s.mode = MODE_LIT; s.lit_sel = LIT_TRUE;  s.lit_pos = 3'd1;
                end
                CH_LOW_F: begin
                    s.mode = MODE_LIT; s.lit_sel = LIT_FALSE; s.lit_pos = 3'd1;
                end
                CH_LOW_N: begin
                    s.mode = MODE_LIT; s.lit_sel = LIT_NULL;  s.lit_pos = 3'd1;
                end
                CH_MINUS: s.mode = MODE_MINUS;
                CH_ZERO:  s.mode = MODE_ZERO;
                CH_QUOTE: s.mode = MODE_STR;
                CH_SLASH: s.mode = MODE_SLASH;
                default: begin
                    priority if (is_digit(c)) begin
                        s.mode = MODE_INT;
                    end else if (is_ws(c)) begin
                        s.mode = MODE_WS;
                    end else begin
                        ev[1] = mk_emit(KIND_UNKNOWN, 1'b0, s.len);
                        s     = IDLE_STATE;
                    end
                end
            endcase
        end

        // end of text flushes whatever is open
        if (i_item.end_of_text) begin
            unique case (s.mode)
                MODE_IDLE: ;
                MODE_LIT: ev[2] = mk_emit(lit_kind(s.lit_sel), 1'b0, s.len);
                MODE_ZERO, MODE_INT, MODE_FRAC, MODE_EXPDIG:
                    ev[2] = mk_emit(KIND_NUMBER, 1'b1, s.len);
                MODE_MINUS, MODE_DOT, MODE_EXP, MODE_EXPSIGN:
                    ev[2] = mk_emit(KIND_NUMBER, 1'b0, s.len);
                MODE_STR: begin
                    ev[2] = mk_emit(KIND_STRING, 1'b0, s.len);
                    // dangling backslash comes out as its own unknown byte
                    if (s.esc) begin
                        ev[3] = mk_emit(KIND_UNKNOWN, 1'b0, {{(LEN_W-1){1'b0}}, 1'b1});
                    end
                end
                MODE_WS: ev[2] = mk_emit(KIND_SPACE, 1'b1, s.len);
                MODE_SLASH, MODE_COMMENT: ev[2] = mk_emit(KIND_COMMENT, 1'b0, s.len);
                default: ;
            endcase
            s = IDLE_STATE;
        end
    end

    // compact the emits into two result slots, in order
    always_comb begin
        n  = 2'd0;
        r0 = '0;
        r1 = '0;
        for (int j = 0; j < 4; j++) begin
            if (ev[j].valid) begin
                if (n == 2'd0) begin
                    r0 = '{token_type: ev[j].kind, matched: ev[j].ok,
                           token_length: ev[j].len, last_of_run: 1'b0};
                    n  = 2'd1;
                end else if (n == 2'd1) begin
                    r1 = '{token_type: ev[j].kind, matched: ev[j].ok,
                           token_length: ev[j].len, last_of_run: 1'b0};
                    n  = 2'd2;
                end
            end
        end
        r0.last_of_run = (n == 2'd1);
        r1.last_of_run = (n == 2'd2);
    end

    assign o_state = s;
    assign o_count = n;
    assign o_res0  = r0;
    assign o_res1  = r1;

endmodule

`default_nettype wire

[rtl/core/jtl_res_queue.sv]
`default_nettype none

// Shift queue of results; head is always entry 0, so the output is registered.
module jtl_res_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [1:0]    i_push_n,
    input  jtl_pkg::t_out i_res0,
    input  jtl_pkg::t_out i_res1,
    output logic          o_room,
    output logic          o_valid,
    input  logic          i_ready,
    output jtl_pkg::t_out o_res
);
    import jtl_pkg::*;

    t_out              r_q [QUEUE_DEPTH];
    t_out              n_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_count;
    logic [QPTR_W-1:0] n_count;
    logic              pop;
    logic [QPTR_W-1:0] base;

    assign pop  = (r_count != '0) && i_ready;
    assign base = r_count - {{(QPTR_W-1){1'b0}}, pop};

    always_comb begin
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
            n_q[j] = r_q[j];
            if (pop && j < QUEUE_DEPTH - 1) begin
                n_q[j] = r_q[(j + 1) % QUEUE_DEPTH];
            end
            if (i_push_n != 2'd0 && base == QPTR_W'(j)) begin
                n_q[j] = i_res0;
            end
            if (i_push_n == 2'd2 && base + QPTR_W'(1) == QPTR_W'(j)) begin
                n_q[j] = i_res1;
            end
        end
        n_count = base + QPTR_W'(i_push_n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    // room for the two results one request can raise
    assign o_room  = r_count <= QPTR_W'(QUEUE_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_res   = r_q[0];

endmodule

`default_nettype wire
